### rtl/tanh_activation_unit_defines.svh
// ----------------------------------------------------------------------------
// tanh activation unit assertion macros
// concurrent checks clocked on clk and held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef TANH_ACTIVATION_UNIT_DEFINES_SVH
`define TANH_ACTIVATION_UNIT_DEFINES_SVH

// same-cycle implication
`define TANH_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tanh activation unit check failed");

// next-cycle implication
`define TANH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tanh activation unit check failed");

`endif

### rtl/tanh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tanh_pkg
// shared payload types and fixed-point constants of the tanh activation unit
// ----------------------------------------------------------------------------
package tanh_pkg;

    typedef struct packed {
        logic               opcode;
        logic signed [15:0] operand_value;
        logic               last_in;
    } operand_t;

    typedef struct packed {
        logic signed [15:0] result_value;
        logic               last_out;
    } result_t;

    localparam logic OP_FORWARD  = 1'b0;
    localparam logic OP_BACKWARD = 1'b1;

    localparam int          SERIES_TERMS = 16;
    localparam int          QUOT_BITS    = 15;
    localparam logic [31:0] Q30_ONE      = 32'h4000_0000;
    localparam logic [29:0] LN2_Q30      = 30'd744261118;
    localparam logic [63:0] LN2_RECIP_W  = (64'd1 << 51) / 64'd744261118;
    localparam logic [21:0] LN2_RECIP    = LN2_RECIP_W[21:0];
    localparam logic [14:0] MAG_MAX      = 15'd16384;

    typedef struct packed {
        logic        opcode;
        logic        last;
        logic        neg;
        logic [4:0]  n;
        logic [29:0] r;
        logic [30:0] term;
        logic [31:0] sum;
    } series_t;

    typedef struct packed {
        logic        opcode;
        logic        last;
        logic        neg;
        logic [46:0] rem;
        logic [32:0] dv;
        logic [14:0] q;
    } div_t;

endpackage

### rtl/tanh_range_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tanh_range_cell
// takes |2x| in q30 apart into n * ln2 + r over three stages
// ----------------------------------------------------------------------------
module tanh_range_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  tanh_pkg::operand_t up_data,
    output logic               dn_valid,
    input  logic               dn_ready,
    output tanh_pkg::series_t  dn_data
);

    logic        v1_reg, v2_reg, v3_reg;
    logic        rdy1, rdy2, rdy3;
    logic        op1_reg, last1_reg, neg1_reg;
    logic [15:0] mag1_reg;
    logic [37:0] prod1_reg;
    logic        op2_reg, last2_reg, neg2_reg;
    logic [4:0]  n2_reg;
    logic [30:0] r2_reg;
    tanh_pkg::series_t out_reg;

    logic [15:0] raw;
    logic        neg1_next;
    logic [15:0] mag1_next;
    logic [37:0] prod1_next;
    logic [4:0]  n2_next;
    logic [34:0] a2, nl2, r2_full;
    logic [30:0] r2_next;
    tanh_pkg::series_t out_next;

    assign rdy3     = !v3_reg || dn_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign up_ready = rdy1;
    assign dn_valid = v3_reg;
    assign dn_data  = out_reg;

    always_comb
    begin
        raw        = up_data.operand_value;
        neg1_next  = raw[15];
        mag1_next  = neg1_next ? 16'(-raw) : raw;
        prod1_next = {22'd0, mag1_next} * {16'd0, tanh_pkg::LN2_RECIP};

        n2_next = prod1_reg[36:32];
        a2      = {mag1_reg, 19'd0};
        nl2     = 35'(n2_next) * {5'd0, tanh_pkg::LN2_Q30};
        r2_full = a2 - nl2;
        r2_next = r2_full[30:0];

        out_next.opcode = op2_reg;
        out_next.last   = last2_reg;
        out_next.neg    = neg2_reg;
        out_next.term   = tanh_pkg::Q30_ONE[30:0];
        out_next.sum    = tanh_pkg::Q30_ONE;
        if (r2_reg >= {1'b0, tanh_pkg::LN2_Q30})
        begin
            out_next.n = n2_reg + 5'd1;
            out_next.r = 30'(r2_reg - {1'b0, tanh_pkg::LN2_Q30});
        end
        else
        begin
            out_next.n = n2_reg;
            out_next.r = r2_reg[29:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= up_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            op1_reg   <= up_data.opcode;
            last1_reg <= up_data.last_in;
            neg1_reg  <= neg1_next;
            mag1_reg  <= mag1_next;
            prod1_reg <= prod1_next;
        end
        if (rdy2)
        begin
            op2_reg   <= op1_reg;
            last2_reg <= last1_reg;
            neg2_reg  <= neg1_reg;
            n2_reg    <= n2_next;
            r2_reg    <= r2_next;
        end
        if (rdy3)
        begin
            out_reg <= out_next;
        end
    end

endmodule

### rtl/tanh_series_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tanh_series_cell
// one taylor term of e^-r: term * r >> 30, then divide by k and accumulate
// ----------------------------------------------------------------------------
module tanh_series_cell #(
    parameter int K = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  tanh_pkg::series_t up_data,
    output logic              dn_valid,
    input  logic              dn_ready,
    output tanh_pkg::series_t dn_data
);

    localparam int          SH      = 31 + $clog2(K);
    localparam logic [63:0] RECIP_W = ((64'd1 << SH) + 64'(K) - 64'd1) / 64'(K);
    localparam logic [31:0] RECIP   = RECIP_W[31:0];
    localparam logic        SUB     = (K % 2) == 1;

    logic              va_reg, vb_reg, rdya, rdyb;
    tanh_pkg::series_t a_reg, b_reg, a_next, b_next;
    logic [60:0]       prod_a;
    logic [63:0]       prod_b, quot_w;
    logic [31:0]       q;

    assign rdyb     = !vb_reg || dn_ready;
    assign rdya     = !va_reg || rdyb;
    assign up_ready = rdya;
    assign dn_valid = vb_reg;
    assign dn_data  = b_reg;

    always_comb
    begin
        prod_a      = {30'd0, up_data.term} * {31'd0, up_data.r};
        a_next      = up_data;
        a_next.term = prod_a[60:30];

        prod_b = {33'd0, a_reg.term} * {32'd0, RECIP};
        quot_w = prod_b >> SH;
        q      = quot_w[31:0];
        b_next      = a_reg;
        b_next.term = q[30:0];
        if (SUB)
            b_next.sum = (a_reg.sum >= q) ? a_reg.sum - q : 32'd0;
        else
            b_next.sum = a_reg.sum + q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (rdya) va_reg <= up_valid;
            if (rdyb) vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdya) a_reg <= a_next;
        if (rdyb) b_reg <= b_next;
    end

endmodule

### rtl/tanh_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tanh_div_cell
// one restoring division step: settles quotient bit BIT
// ----------------------------------------------------------------------------
module tanh_div_cell #(
    parameter int BIT = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    output logic           up_ready,
    input  tanh_pkg::div_t up_data,
    output logic           dn_valid,
    input  logic           dn_ready,
    output tanh_pkg::div_t dn_data
);

    logic           v_reg, rdy;
    tanh_pkg::div_t d_reg, d_next;
    logic [46:0]    shifted;
    logic [47:0]    diff;

    assign rdy      = !v_reg || dn_ready;
    assign up_ready = rdy;
    assign dn_valid = v_reg;
    assign dn_data  = d_reg;

    always_comb
    begin
        shifted = {14'd0, up_data.dv} << BIT;
        diff    = {1'b0, up_data.rem} - {1'b0, shifted};
        d_next  = up_data;
        if (!diff[47])
        begin
            d_next.rem    = diff[46:0];
            d_next.q[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (rdy)
            v_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy) d_reg <= d_next;
    end

endmodule

### rtl/tanh_activation_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tanh_activation_unit
// elementwise tanh (q4.12 in, q1.14 out) and its derivative 1 - tanh^2
// ----------------------------------------------------------------------------
// channel   handshake                      payload
// operand   operand_valid / operand_ready  opcode, operand_value, last_in
// result    result_valid / result_ready    result_value, last_out
//
// one transfer per cycle sustained while the result is taken; the chain is built of
// 3 range stages, 16 series cells of 2 stages, 1 scale, 15 divide cells, 2 out
// every stage has its own valid and hands on when the next one has room
// reset clears valid bits only; a stall at the output backs up stage by stage
// ----------------------------------------------------------------------------
`include "tanh_activation_unit_defines.svh"

module tanh_activation_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               operand_valid,
    output logic               operand_ready,
    input  tanh_pkg::operand_t operand,
    output logic               result_valid,
    input  logic               result_ready,
    output tanh_pkg::result_t  result
);

    localparam int NS = tanh_pkg::SERIES_TERMS;
    localparam int ND = tanh_pkg::QUOT_BITS;

    tanh_pkg::series_t ser_data  [0:NS];
    logic              ser_valid [0:NS];
    logic              ser_ready [0:NS];
    tanh_pkg::div_t    div_data  [0:ND];
    logic              div_valid [0:ND];
    logic              div_ready [0:ND];

    tanh_range_cell u_range (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (operand_valid),
        .up_ready (operand_ready),
        .up_data  (operand),
        .dn_valid (ser_valid[0]),
        .dn_ready (ser_ready[0]),
        .dn_data  (ser_data[0])
    );

    for (genvar i = 0; i < NS; i++)
    begin : g_series
        tanh_series_cell #(.K(i + 1)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (ser_valid[i]),
            .up_ready (ser_ready[i]),
            .up_data  (ser_data[i]),
            .dn_valid (ser_valid[i+1]),
            .dn_ready (ser_ready[i+1]),
            .dn_data  (ser_data[i+1])
        );
    end

    // scale stage: e^-2|x| = sum >> n, then numerator and divisor
    logic           sc_valid_reg, sc_rdy;
    tanh_pkg::div_t sc_reg, sc_next;
    logic [31:0]    e_sh, e_cl, den;
    logic [30:0]    num;

    assign sc_rdy        = !sc_valid_reg || div_ready[0];
    assign ser_ready[NS] = sc_rdy;
    assign div_valid[0]  = sc_valid_reg;
    assign div_data[0]   = sc_reg;

    always_comb
    begin
        e_sh = ser_data[NS].sum >> ser_data[NS].n;
        e_cl = (e_sh > tanh_pkg::Q30_ONE) ? tanh_pkg::Q30_ONE : e_sh;
        num  = 31'(tanh_pkg::Q30_ONE - e_cl);
        den  = tanh_pkg::Q30_ONE + e_cl;
        sc_next.opcode = ser_data[NS].opcode;
        sc_next.last   = ser_data[NS].last;
        sc_next.neg    = ser_data[NS].neg;
        sc_next.rem    = {1'b0, num, 15'd0} + {15'd0, den};
        sc_next.dv     = {den, 1'b0};
        sc_next.q      = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sc_valid_reg <= 1'b0;
        else if (sc_rdy)
            sc_valid_reg <= ser_valid[NS];
    end

    always_ff @(posedge clk)
    begin
        if (sc_rdy) sc_reg <= sc_next;
    end

    for (genvar j = 0; j < ND; j++)
    begin : g_div
        tanh_div_cell #(.BIT(ND - 1 - j)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (div_valid[j]),
            .up_ready (div_ready[j]),
            .up_data  (div_data[j]),
            .dn_valid (div_valid[j+1]),
            .dn_ready (div_ready[j+1]),
            .dn_data  (div_data[j+1])
        );
    end

    // square stage, then output register
    logic               f1_valid_reg, f1_rdy, f2_rdy;
    logic               f1_op_reg, f1_last_reg, out_op_reg;
    logic signed [15:0] f1_t_reg, f1_t_next;
    logic [29:0]        f1_sq_reg, f1_sq_next;
    logic [14:0]        mag;
    logic [29:0]        sq_rnd;
    logic [15:0]        deriv;
    tanh_pkg::result_t  out_reg, out_next;

    assign f2_rdy        = !result_valid || result_ready;
    assign f1_rdy        = !f1_valid_reg || f2_rdy;
    assign div_ready[ND] = f1_rdy;
    assign result        = out_reg;

    always_comb
    begin
        mag        = (div_data[ND].q > tanh_pkg::MAG_MAX) ? tanh_pkg::MAG_MAX
                                                          : div_data[ND].q;
        f1_sq_next = {15'd0, mag} * {15'd0, mag};
        f1_t_next  = div_data[ND].neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

        sq_rnd = f1_sq_reg + 30'd8192;
        deriv  = 16'(16'd16384 - sq_rnd[29:14]);
        out_next.last_out     = f1_last_reg;
        out_next.result_value = (f1_op_reg == tanh_pkg::OP_BACKWARD) ? $signed(deriv)
                                                                     : f1_t_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            if (f1_rdy) f1_valid_reg <= div_valid[ND];
            if (f2_rdy) result_valid <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f1_rdy)
        begin
            f1_op_reg   <= div_data[ND].opcode;
            f1_last_reg <= div_data[ND].last;
            f1_t_reg    <= f1_t_next;
            f1_sq_reg   <= f1_sq_next;
        end
        if (f2_rdy)
        begin
            out_reg    <= out_next;
            out_op_reg <= f1_op_reg;
        end
    end

    logic res_in_range;

    assign res_in_range = (result.result_value <= 16'sd16384)
                       && (result.result_value >= -16'sd16384);

    `TANH_ASSERT_IMPLY(a_deriv_nonneg, result_valid && out_op_reg, !result.result_value[15])
    `TANH_ASSERT_IMPLY(a_result_range, result_valid, res_in_range)
    `TANH_ASSERT_NEXT(a_out_advance, f1_valid_reg && f2_rdy, result_valid)

endmodule
